// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the datetime difference unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: rtl/rdds_pkg.sv
// Types, constants and calendar helpers of the datetime difference unit.
package rdds_pkg;

  localparam int YearW = 7;
  localparam int MonW  = 4;
  localparam int DayW  = 5;
  localparam int HourW = 5;
  localparam int MinW  = 6;
  localparam int SecW  = 6;
  localparam int OutW  = 32;

  // Signed day count, then signed second count, in the accumulator.
  localparam int DayAccW = 18;
  localparam int AccW    = 34;
  localparam int OpW     = 17;

  localparam int SecsPerDay  = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;
  localparam int YearDays    = 365;

  // Year offsets from 2000: whole years count from 2010, 2100 is not leap.
  localparam logic [YearW-1:0] CountFromYear = YearW'(10);
  localparam logic [YearW-1:0] CenturySkip   = YearW'(100);
  localparam logic [MonW-1:0]  MonthsPerYear = MonW'(12);

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  sec;
  } stamp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_YEAR,
    S_MON_L,
    S_MON_E,
    S_DAY_L,
    S_DAY_E,
    S_SCALE,
    S_HOUR_L,
    S_HOUR_E,
    S_MIN_L,
    S_MIN_E,
    S_SEC_L,
    S_SEC_E,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    SEL_YEAR,
    SEL_MON,
    SEL_DAY,
    SEL_HOUR,
    SEL_MIN,
    SEL_SEC
  } sel_e;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic             sub;
    logic             scale;
    logic             use_earlier;
    sel_e             sel;
    logic [YearW-1:0] year;
    logic [MonW-1:0]  mon_idx;
  } alu_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } sts_t;

  // Gregorian rule over offsets 0..127: 2000 is leap, 2100 is not.
  function automatic logic leap_year(input logic [YearW-1:0] yoff);
    leap_year = (yoff[1:0] == 2'b00) && (yoff != CenturySkip);
  endfunction

  function automatic logic [4:0] month_days(input logic [MonW-1:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd0;
    endcase
    month_days = len;
  endfunction

endpackage

// File: rtl/rtc_datetime_difference_seconds_unit.sv
// Top level of the RTC datetime difference unit: handshake, capture and result register.
// Computes the seconds from an earlier RTC timestamp to a later one (years as offsets from
// 2000, Gregorian leap years, whole years counted from 2010; years before 2010 contribute
// only their within-year seconds) and returns the difference, or 0 when the later stamp is
// not after the earlier one. One transaction is worked on at a time: in_ready_o is high only
// while the sequencer is idle. The sequencer walks the whole years between the two stamps
// (after clamping both to 2010, at most 117), then the months before each stamp's month (at
// most 12 each). The work runs through one shared accumulator, which takes one year or one
// month per cycle, then each remaining term in turn (days, the day-to-second scale, hours,
// minutes, seconds). A finished result waits in the output register; the sequencer only
// holds its final state when that register is still full, and returns to idle the cycle
// after it hands the result over.
`include "assert_macros.svh"

module rtc_datetime_difference_seconds_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [6:0]                later_year_i,
  input  logic [3:0]                later_month_i,
  input  logic [4:0]                later_day_i,
  input  logic [4:0]                later_hour_i,
  input  logic [5:0]                later_minute_i,
  input  logic [5:0]                later_sec_i,
  input  logic [6:0]                earlier_year_i,
  input  logic [3:0]                earlier_month_i,
  input  logic [4:0]                earlier_day_i,
  input  logic [4:0]                earlier_hour_i,
  input  logic [5:0]                earlier_minute_i,
  input  logic [5:0]                earlier_sec_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [31:0]               diff_seconds_o
);
  import rdds_pkg::*;

  stamp_t          later_q, earlier_q;
  alu_ctrl_t       alu_ctrl;
  sts_t            sts;
  logic [OutW-1:0] result;
  logic [OutW-1:0] out_q;
  logic            out_valid_q, out_valid_d;
  logic            in_accept;
  logic            done_ack;

  assign in_ready_o = sts.idle;
  assign in_accept  = in_valid_i && in_ready_o;

  // Hand the result over once the output register is empty or being drained.
  assign done_ack = sts.done && (!out_valid_q || out_ready_i);

  // Hold both stamps for the whole transaction.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      later_q   <= '{year: later_year_i, month: later_month_i, day: later_day_i,
                     hour: later_hour_i, minute: later_minute_i, sec: later_sec_i};
      earlier_q <= '{year: earlier_year_i, month: earlier_month_i, day: earlier_day_i,
                     hour: earlier_hour_i, minute: earlier_minute_i, sec: earlier_sec_i};
    end
  end

  rdds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .done_ack_i (done_ack),
    .later_i    (later_q),
    .earlier_i  (earlier_q),
    .ctrl_o     (alu_ctrl),
    .sts_o      (sts)
  );

  rdds_alu u_alu (
    .clk_i     (clk_i),
    .ctrl_i    (alu_ctrl),
    .later_i   (later_q),
    .earlier_i (earlier_q),
    .result_o  (result)
  );

  // Load on hand-over, drop when the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (done_ack) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_ack) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign diff_seconds_o = out_q;

  `ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> $past(sts.done), "result without finished work")
  `ASSERT_CLK(a_accept_starts, in_accept |=> !sts.idle, "accepted transaction not started")
  `ASSERT_NEVER(a_done_blocks_input, sts.done && in_ready_o, "input open while result pending")

endmodule

// File: rtl/rdds_ctrl.sv
// Sequencer of the datetime difference unit: year walk, month walks, fixed steps.
module rdds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                done_ack_i,
  input  rdds_pkg::stamp_t    later_i,
  input  rdds_pkg::stamp_t    earlier_i,
  output rdds_pkg::alu_ctrl_t ctrl_o,
  output rdds_pkg::sts_t      sts_o
);
  import rdds_pkg::*;

  state_e           state_q, state_d;
  logic [YearW-1:0] year_q, year_d;
  logic [MonW-1:0]  mon_q, mon_d;

  logic [YearW-1:0] clamp_l, clamp_e, year_lo, year_hi;
  logic             year_sub;
  logic [MonW-1:0]  walk_l, walk_e;

  function automatic logic [MonW-1:0] month_walk(input logic [MonW-1:0] m);
    logic [MonW-1:0] w;
    if (m == '0) begin
      w = '0;
    end else if (m > MonthsPerYear) begin
      w = MonthsPerYear;
    end else begin
      w = m - MonW'(1);
    end
    month_walk = w;
  endfunction

  // Years before the count start add no whole-year days.
  assign clamp_l  = (later_i.year < CountFromYear) ? CountFromYear : later_i.year;
  assign clamp_e  = (earlier_i.year < CountFromYear) ? CountFromYear : earlier_i.year;
  assign year_sub = clamp_l < clamp_e;
  assign year_lo  = year_sub ? clamp_l : clamp_e;
  assign year_hi  = year_sub ? clamp_e : clamp_l;
  assign walk_l   = month_walk(later_i.month);
  assign walk_e   = month_walk(earlier_i.month);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_INIT;
      S_INIT:   state_d = S_YEAR;
      S_YEAR:   if (year_q == year_hi) state_d = S_MON_L;
      S_MON_L:  if (mon_q == walk_l) state_d = S_MON_E;
      S_MON_E:  if (mon_q == walk_e) state_d = S_DAY_L;
      S_DAY_L:  state_d = S_DAY_E;
      S_DAY_E:  state_d = S_SCALE;
      S_SCALE:  state_d = S_HOUR_L;
      S_HOUR_L: state_d = S_HOUR_E;
      S_HOUR_E: state_d = S_MIN_L;
      S_MIN_L:  state_d = S_MIN_E;
      S_MIN_E:  state_d = S_SEC_L;
      S_SEC_L:  state_d = S_SEC_E;
      S_SEC_E:  state_d = S_DONE;
      S_DONE:   if (done_ack_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    year_d             = year_q;
    mon_d              = mon_q;
    ctrl_o.clr         = 1'b0;
    ctrl_o.en          = 1'b0;
    ctrl_o.sub         = 1'b0;
    ctrl_o.scale       = 1'b0;
    ctrl_o.use_earlier = 1'b0;
    ctrl_o.sel         = SEL_YEAR;
    ctrl_o.year        = year_q;
    ctrl_o.mon_idx     = mon_q;
    sts_o.idle         = 1'b0;
    sts_o.done         = 1'b0;
    unique case (state_q)
      S_IDLE: sts_o.idle = 1'b1;
      S_INIT: begin
        ctrl_o.clr = 1'b1;
        year_d     = year_lo;
        mon_d      = '0;
      end
      S_YEAR: begin
        ctrl_o.sel = SEL_YEAR;
        ctrl_o.sub = year_sub;
        if (year_q != year_hi) begin
          ctrl_o.en = 1'b1;
          year_d    = year_q + YearW'(1);
        end
      end
      S_MON_L: begin
        ctrl_o.sel = SEL_MON;
        if (mon_q != walk_l) begin
          ctrl_o.en = 1'b1;
          mon_d     = mon_q + MonW'(1);
        end else begin
          mon_d = '0;
        end
      end
      S_MON_E: begin
        ctrl_o.sel         = SEL_MON;
        ctrl_o.use_earlier = 1'b1;
        ctrl_o.sub         = 1'b1;
        if (mon_q != walk_e) begin
          ctrl_o.en = 1'b1;
          mon_d     = mon_q + MonW'(1);
        end
      end
      S_DAY_L: begin
        ctrl_o.sel = SEL_DAY;
        ctrl_o.en  = 1'b1;
      end
      S_DAY_E: begin
        ctrl_o.sel         = SEL_DAY;
        ctrl_o.en          = 1'b1;
        ctrl_o.sub         = 1'b1;
        ctrl_o.use_earlier = 1'b1;
      end
      S_SCALE: ctrl_o.scale = 1'b1;
      S_HOUR_L: begin
        ctrl_o.sel = SEL_HOUR;
        ctrl_o.en  = 1'b1;
      end
      S_HOUR_E: begin
        ctrl_o.sel         = SEL_HOUR;
        ctrl_o.en          = 1'b1;
        ctrl_o.sub         = 1'b1;
        ctrl_o.use_earlier = 1'b1;
      end
      S_MIN_L: begin
        ctrl_o.sel = SEL_MIN;
        ctrl_o.en  = 1'b1;
      end
      S_MIN_E: begin
        ctrl_o.sel         = SEL_MIN;
        ctrl_o.en          = 1'b1;
        ctrl_o.sub         = 1'b1;
        ctrl_o.use_earlier = 1'b1;
      end
      S_SEC_L: begin
        ctrl_o.sel = SEL_SEC;
        ctrl_o.en  = 1'b1;
      end
      S_SEC_E: begin
        ctrl_o.sel         = SEL_SEC;
        ctrl_o.en          = 1'b1;
        ctrl_o.sub         = 1'b1;
        ctrl_o.use_earlier = 1'b1;
      end
      S_DONE: sts_o.done = 1'b1;
      default: sts_o.idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      year_q  <= '0;
      mon_q   <= '0;
    end else begin
      state_q <= state_d;
      year_q  <= year_d;
      mon_q   <= mon_d;
    end
  end

endmodule

// File: rtl/rdds_alu.sv
// Shared add/subtract accumulator with operand select and day-to-second scaling.
module rdds_alu (
  input  logic                          clk_i,
  input  rdds_pkg::alu_ctrl_t           ctrl_i,
  input  rdds_pkg::stamp_t              later_i,
  input  rdds_pkg::stamp_t              earlier_i,
  output logic [rdds_pkg::OutW-1:0]     result_o
);
  import rdds_pkg::*;

  localparam logic signed [DayAccW-1:0] DaySecs = DayAccW'(SecsPerDay);

  logic [AccW-1:0]               acc_q, acc_d;
  logic [OpW-1:0]                operand;
  logic signed [2*DayAccW-1:0]   prod;
  stamp_t                        st;
  logic                          positive;

  assign st = ctrl_i.use_earlier ? earlier_i : later_i;

  always_comb begin
    case (ctrl_i.sel)
      SEL_YEAR: operand = leap_year(ctrl_i.year) ? OpW'(YearDays + 1) : OpW'(YearDays);
      SEL_MON:  operand = OpW'(month_days(ctrl_i.mon_idx, leap_year(st.year)));
      SEL_DAY:  operand = OpW'(st.day);
      SEL_HOUR: operand = OpW'(st.hour) * OpW'(SecsPerHour);
      SEL_MIN:  operand = OpW'(st.minute) * OpW'(SecsPerMin);
      SEL_SEC:  operand = OpW'(st.sec);
      default:  operand = '0;
    endcase
  end

  // Day count is small enough to sit in the low bits before scaling.
  assign prod = $signed(acc_q[DayAccW-1:0]) * DaySecs;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.scale) begin
      acc_d = prod[AccW-1:0];
    end else if (ctrl_i.en) begin
      acc_d = ctrl_i.sub ? acc_q - AccW'(operand) : acc_q + AccW'(operand);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign positive = !acc_q[AccW-1] && (acc_q != '0);
  assign result_o = positive ? acc_q[OutW-1:0] : '0;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the RTC datetime difference unit.
`timescale 1ns / 100ps

module testbench;
  import rdds_pkg::*;

  localparam int unsigned BaseYear        = 2000;
  localparam int unsigned FirstWholeYear  = 2010;
  localparam int unsigned DrainCycles     = 200;   // above the worst-case latency
  localparam longint      TimeoutNs       = 40_000_000;

  // Clock, reset and every DUT input start at a known value.
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [6:0]  later_year_i    = '0;
  logic [3:0]  later_month_i   = '0;
  logic [4:0]  later_day_i     = '0;
  logic [4:0]  later_hour_i    = '0;
  logic [5:0]  later_minute_i  = '0;
  logic [5:0]  later_sec_i     = '0;
  logic [6:0]  earlier_year_i  = '0;
  logic [3:0]  earlier_month_i = '0;
  logic [4:0]  earlier_day_i   = '0;
  logic [4:0]  earlier_hour_i  = '0;
  logic [5:0]  earlier_minute_i = '0;
  logic [5:0]  earlier_sec_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [31:0] diff_seconds_o;

  // Differences still owed by the DUT, oldest first.
  bit [31:0] pending_diffs[$];

  int unsigned n_pairs_sent   = 0;
  int unsigned n_diffs_seen   = 0;
  int unsigned n_zero_diffs   = 0;
  int unsigned n_errors       = 0;
  int unsigned ready_hold     = 0;

  // While set, both sides run back to back without idling.
  bit steady = 1'b1;

  always #5 clk_i = ~clk_i;

  rtc_datetime_difference_seconds_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .later_year_i    (later_year_i),
    .later_month_i   (later_month_i),
    .later_day_i     (later_day_i),
    .later_hour_i    (later_hour_i),
    .later_minute_i  (later_minute_i),
    .later_sec_i     (later_sec_i),
    .earlier_year_i  (earlier_year_i),
    .earlier_month_i (earlier_month_i),
    .earlier_day_i   (earlier_day_i),
    .earlier_hour_i  (earlier_hour_i),
    .earlier_minute_i(earlier_minute_i),
    .earlier_sec_i   (earlier_sec_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .diff_seconds_o  (diff_seconds_o)
  );

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------

  // Gregorian rule on the full year number.
  function automatic bit is_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Length of month idx, counted from 0 = January.
  function automatic int unsigned month_length(input int unsigned idx, input bit leap);
    case (idx)
      0, 2, 4, 6, 7, 9, 11: return 31;
      1:                    return leap ? 29 : 28;
      default:              return 30;
    endcase
  endfunction

  // Seconds since the start of 2010. Years before 2010 add no whole-year days,
  // month 0 walks no months, months past December walk all twelve, and day 0
  // lands one day before the first of the month. Hour, minute and second are
  // weighted as given, even out of range.
  function automatic longint stamp_to_secs(input stamp_t s);
    longint      days;
    int unsigned yr;
    int unsigned y;
    int unsigned walk;
    int unsigned k;
    bit          leap;
    yr   = BaseYear + s.year;
    leap = is_leap(yr);
    days = 0;
    for (y = FirstWholeYear; y < yr; y++) begin
      days += is_leap(y) ? 366 : 365;
    end
    walk = (s.month == 0) ? 0 : s.month - 1;
    if (walk > 12) begin
      walk = 12;
    end
    for (k = 0; k < walk; k++) begin
      days += month_length(k, leap);
    end
    days += longint'(s.day) - 1;
    return days * SecsPerDay + longint'(s.hour) * SecsPerHour
         + longint'(s.minute) * SecsPerMin + longint'(s.sec);
  endfunction

  // Later minus earlier, floored at zero.
  function automatic bit [31:0] elapsed_secs(input stamp_t newer, input stamp_t older);
    longint t_new;
    longint t_old;
    t_new = stamp_to_secs(newer);
    t_old = stamp_to_secs(older);
    return (t_new > t_old) ? 32'(t_new - t_old) : 32'd0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stamp_t mk_stamp(input int yr, input int mon, input int dy,
                                      input int hr, input int mn, input int sc);
    stamp_t s;
    s.year   = YearW'(yr);
    s.month  = MonW'(mon);
    s.day    = DayW'(dy);
    s.hour   = HourW'(hr);
    s.minute = MinW'(mn);
    s.sec    = SecW'(sc);
    return s;
  endfunction

  // A real date and time between 2000 and 2099.
  function automatic stamp_t rand_calendar_stamp();
    stamp_t s;
    s.year   = YearW'($urandom_range(0, 99));
    s.month  = MonW'($urandom_range(1, 12));
    s.day    = DayW'($urandom_range(1, month_length(s.month - 1, is_leap(BaseYear + s.year))));
    s.hour   = HourW'($urandom_range(0, 23));
    s.minute = MinW'($urandom_range(0, 59));
    s.sec    = SecW'($urandom_range(0, 59));
    return s;
  endfunction

  // Any bit pattern the ports can carry.
  function automatic stamp_t rand_raw_stamp();
    stamp_t s;
    s.year   = YearW'($urandom);
    s.month  = MonW'($urandom);
    s.day    = DayW'($urandom);
    s.hour   = HourW'($urandom);
    s.minute = MinW'($urandom);
    s.sec    = SecW'($urandom);
    return s;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input bit [31:0] got,
                                 input bit [31:0] want);
    n_errors++;
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Present one pair of stamps and hold it until the DUT takes it. Enter just
  // after a rising edge; return at the rising edge of acceptance.
  task automatic send_pair(input stamp_t newer, input stamp_t older);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    later_year_i     <= newer.year;
    later_month_i    <= newer.month;
    later_day_i      <= newer.day;
    later_hour_i     <= newer.hour;
    later_minute_i   <= newer.minute;
    later_sec_i      <= newer.sec;
    earlier_year_i   <= older.year;
    earlier_month_i  <= older.month;
    earlier_day_i    <= older.day;
    earlier_hour_i   <= older.hour;
    earlier_minute_i <= older.minute;
    earlier_sec_i    <= older.sec;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_diffs.push_back(elapsed_secs(newer, older));
    n_pairs_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Toggle ready with random hold times; keep it high in steady stretches.
  always @(negedge clk_i) begin
    if (!rst_ni || steady) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready_i <= ~out_ready_i;
      ready_hold  <= pick_gap();
    end
  end

  // Compare each result transaction with the oldest owed difference.
  always @(posedge clk_i) begin
    bit [31:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_diffs_seen++;
      if (pending_diffs.size() == 0) begin
        report_mismatch("unexpected result", diff_seconds_o, 32'd0);
      end else begin
        want = pending_diffs.pop_front();
        if (want == 0) n_zero_diffs++;
        if (diff_seconds_o !== want) begin
          report_mismatch("diff_seconds", diff_seconds_o, want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked corners: range ends, ordering, pre-2010 years, leap rules and
  // out-of-range field values.
  task automatic test_calendar_corners();
    // identical stamps give zero
    send_pair(mk_stamp(24, 6, 15, 12, 30, 45), mk_stamp(24, 6, 15, 12, 30, 45));
    // later stamp actually earlier: clamp to zero
    send_pair(mk_stamp(20, 3, 1, 0, 0, 0), mk_stamp(30, 3, 1, 0, 0, 0));
    // one second the wrong way
    send_pair(mk_stamp(55, 7, 7, 7, 7, 6), mk_stamp(55, 7, 7, 7, 7, 7));
    // full legal span
    send_pair(mk_stamp(99, 12, 31, 23, 59, 59), mk_stamp(0, 1, 1, 0, 0, 0));
    // 2000 and 2010 both map to zero whole-year days
    send_pair(mk_stamp(10, 1, 1, 0, 0, 0), mk_stamp(0, 1, 1, 0, 0, 0));
    send_pair(mk_stamp(9, 12, 31, 23, 59, 59), mk_stamp(10, 1, 1, 0, 0, 0));
    send_pair(mk_stamp(10, 1, 1, 0, 0, 1), mk_stamp(10, 1, 1, 0, 0, 0));
    // leap Februaries: 2000 and 2004 leap, 2100 not
    send_pair(mk_stamp(0, 3, 1, 0, 0, 0), mk_stamp(0, 2, 28, 0, 0, 0));
    send_pair(mk_stamp(4, 3, 1, 0, 0, 0), mk_stamp(4, 2, 28, 0, 0, 0));
    send_pair(mk_stamp(100, 3, 1, 0, 0, 0), mk_stamp(100, 2, 28, 0, 0, 0));
    // every field at all ones against the smallest stamp
    send_pair(mk_stamp(127, 15, 31, 31, 63, 63), mk_stamp(0, 0, 0, 0, 0, 0));
    // month zero behaves like January
    send_pair(mk_stamp(15, 0, 5, 0, 0, 0), mk_stamp(15, 1, 4, 0, 0, 0));
    // month past December walks all twelve months
    send_pair(mk_stamp(15, 13, 1, 0, 0, 0), mk_stamp(15, 12, 31, 0, 0, 0));
    // day zero sits one day before the first
    send_pair(mk_stamp(15, 3, 0, 0, 0, 0), mk_stamp(15, 2, 27, 0, 0, 0));
    // hour, minute, second out of range are weighted as given
    send_pair(mk_stamp(15, 6, 1, 31, 63, 63), mk_stamp(15, 6, 1, 0, 0, 0));
    // all-zero stamps
    send_pair(mk_stamp(0, 0, 0, 0, 0, 0), mk_stamp(0, 0, 0, 0, 0, 0));
    // largest year walk from the low end
    send_pair(mk_stamp(127, 1, 1, 0, 0, 0), mk_stamp(10, 1, 1, 0, 0, 0));
  endtask

  // Real calendar stamps in random order; the first stretch runs without idling.
  task automatic test_random_calendar(input int unsigned count);
    stamp_t a;
    stamp_t b;
    for (int unsigned i = 0; i < count; i++) begin
      steady = (i < 150) || ($urandom_range(0, 19) == 0);
      a = rand_calendar_stamp();
      b = rand_calendar_stamp();
      send_pair(a, b);
    end
    steady = 1'b0;
  endtask

  // Stamps within the same month, so small differences and both orders.
  task automatic test_close_stamps(input int unsigned count);
    stamp_t a;
    stamp_t b;
    for (int unsigned i = 0; i < count; i++) begin
      a = rand_calendar_stamp();
      b = a;
      b.day    = DayW'($urandom_range(1, month_length(a.month - 1,
                                                     is_leap(BaseYear + a.year))));
      b.hour   = HourW'($urandom_range(0, 23));
      b.minute = MinW'($urandom_range(0, 59));
      b.sec    = SecW'($urandom_range(0, 59));
      if ($urandom_range(0, 1)) send_pair(a, b);
      else                      send_pair(b, a);
    end
  endtask

  // Arbitrary bit patterns on every field.
  task automatic test_raw_fields(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pair(rand_raw_stamp(), rand_raw_stamp());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    steady = 1'b1;
    test_calendar_corners();
    steady = 1'b0;
    test_random_calendar(750);
    test_close_stamps(200);
    test_raw_fields(250);

    // drop valid once the last transaction is in
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then give a stray result time to show up
    while (pending_diffs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d timestamp pairs; checked %0d differences, %0d of them clamped to zero.",
             n_pairs_sent, n_diffs_seen, n_zero_diffs);
    $display("Covered calendar corners, random dates 2000-2099, close pairs and raw field bits.");
    if (n_errors == 0) begin
      $display("[rtc_datetime_difference_seconds_unit] OK");
    end else begin
      $display("[rtc_datetime_difference_seconds_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #(TimeoutNs);
    $display("%0t: timeout with %0d differences outstanding", $time, pending_diffs.size());
    $display("[rtc_datetime_difference_seconds_unit] ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rdds_pkg.sv
rtl/rdds_ctrl.sv
rtl/rdds_alu.sv
rtl/rtc_datetime_difference_seconds_unit.sv
dv/testbench.sv
